/* rtl/luhn_card_number_check_core_macros.svh */
// ----------------------------------------------------------------------------
// Luhn card check assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LUHN_CARD_NUMBER_CHECK_CORE_MACROS_SVH
`define LUHN_CARD_NUMBER_CHECK_CORE_MACROS_SVH

// same-cycle implication
`define LCCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lccc assertion failed");

// next-cycle implication
`define LCCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lccc assertion failed");

`endif

/* rtl/lccc_pkg.sv */
// ----------------------------------------------------------------------------
// Luhn card check package
// Widths, brand codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package lccc_pkg;

    localparam int CARD_W     = 54;               // binary card number width
    localparam int NDIG       = 17;               // decimal digits of a 54-bit value
    localparam int BCD_W      = NDIG * 4;
    localparam int CNT_W      = $clog2(CARD_W);
    localparam int IDX_W      = $clog2(NDIG);
    localparam int COUNT_W    = 5;
    localparam int MAX_DIGITS = 16;

    localparam logic [1:0] BRAND_INVALID = 2'd0;
    localparam logic [1:0] BRAND_AMEX    = 2'd1;
    localparam logic [1:0] BRAND_MASTER  = 2'd2;
    localparam logic [1:0] BRAND_VISA    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic               luhn_ok;
        logic [COUNT_W-1:0] digit_count;
        logic [1:0]         brand;
    } t_result;

endpackage

/* rtl/luhn_card_number_check_core.sv */
// ----------------------------------------------------------------------------
// Luhn card number check core
// Binary card number in, Luhn pass flag, digit count and brand out.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_card_number
//   out      output     o_out_valid / i_out_stall  o_luhn_ok, o_digit_count, o_brand
//
// From acceptance the core loads the converter, shifts once per card number
// bit, loads the digit scanner, steps once per decimal digit and fills the
// output register.
// One number is in flight at a time; o_in_stall is high until its result
// sits in the output register. A stalled result in the output register
// holds the scanner, and so the input, once the next number is scanned.
// Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module luhn_card_number_check_core
    import lccc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CARD_W-1:0]  i_card_number,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_luhn_ok,
    output logic [COUNT_W-1:0] o_digit_count,
    output logic [1:0]         o_brand
);

`include "luhn_card_number_check_core_macros.svh"

    t_state r_state;
    t_state n_state;

    logic             w_start_conv;
    logic             w_start_scan;
    logic             w_load_out;
    logic             w_conv_done;
    logic             w_scan_done;
    logic [BCD_W-1:0] w_bcd;
    t_result          w_res;

    logic    r_out_valid;
    t_result r_out;

    lccc_bin2bcd u_bin2bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_conv),
        .i_bin   (i_card_number),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    lccc_digit_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_scan),
        .i_bcd   (w_bcd),
        .o_done  (w_scan_done),
        .o_res   (w_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (w_conv_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_done && (!r_out_valid || !i_out_stall)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = 1'b1;
        w_start_conv = 1'b0;
        w_start_scan = 1'b0;
        w_load_out   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                w_start_conv = i_in_valid;
            end
            S_CONV: begin
                w_start_scan = w_conv_done;
            end
            S_SCAN: begin
                // hold the scanner result until the output register frees up
                w_load_out = w_scan_done && (!r_out_valid || !i_out_stall);
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_luhn_ok     = r_out.luhn_ok;
    assign o_digit_count = r_out.digit_count;
    assign o_brand       = r_out.brand;

    `LCCC_ASSERT_NOW(a_brand_needs_pass, o_out_valid && o_brand != BRAND_INVALID, o_luhn_ok)
    `LCCC_ASSERT_NOW(a_count_in_range, o_out_valid, o_digit_count <= COUNT_W'(MAX_DIGITS))
    `LCCC_ASSERT_NEXT(a_accept_starts_conv, i_in_valid && !o_in_stall, r_state == S_CONV)
    `LCCC_ASSERT_NOW(a_no_overwrite, w_load_out, !(r_out_valid && i_out_stall))

endmodule

/* rtl/lccc_bin2bcd.sv */
// ----------------------------------------------------------------------------
// Luhn card check binary to BCD converter
// Shift-add-3 conversion, one input bit per cycle.
// ----------------------------------------------------------------------------
module lccc_bin2bcd
    import lccc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CARD_W-1:0] i_bin,
    output logic              o_done,
    output logic [BCD_W-1:0]  o_bcd
);

    logic [CARD_W-1:0] r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [BCD_W-1:0]  n_adj;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            if (r_bcd[k*4 +: 4] >= 4'd5) begin
                n_adj[k*4 +: 4] = r_bcd[k*4 +: 4] + 4'd3;
            end else begin
                n_adj[k*4 +: 4] = r_bcd[k*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(CARD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[CARD_W-2:0], 1'b0};
            r_bcd <= {n_adj[BCD_W-2:0], r_bin[CARD_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

/* rtl/lccc_digit_scan.sv */
// ----------------------------------------------------------------------------
// Luhn card check digit scanner
// Walks the BCD digits from the right, one per cycle: Luhn sum mod 10,
// significant digit count, leading two digits, then brand classification.
// ----------------------------------------------------------------------------
module lccc_digit_scan
    import lccc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [BCD_W-1:0] i_bcd,
    output logic             o_done,
    output t_result          o_res
);

    logic [BCD_W-1:0]   r_bcd;
    logic [IDX_W-1:0]   r_idx;
    logic               r_busy;
    logic               r_done;
    logic [3:0]         r_sum;
    logic [COUNT_W-1:0] r_count;
    logic [3:0]         r_lead1;
    logic [3:0]         r_lead2;
    logic [3:0]         r_last;

    logic [3:0] w_digit;
    logic [4:0] w_dbl;
    logic [4:0] w_term;
    logic [4:0] w_acc;
    logic [3:0] n_sum;

    assign w_digit = r_bcd[3:0];
    assign w_dbl   = {w_digit, 1'b0};

    always_comb begin
        // odd positions from the right, counted from zero, are doubled, folded back above 9
        if (r_idx[0]) begin
            w_term = (w_digit >= 4'd5) ? (w_dbl - 5'd9) : w_dbl;
        end else begin
            w_term = {1'b0, w_digit};
        end
        w_acc = {1'b0, r_sum} + w_term;
        n_sum = (w_acc >= 5'd10) ? 4'(w_acc - 5'd10) : w_acc[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == IDX_W'(NDIG - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bcd   <= i_bcd;
            r_sum   <= '0;
            r_count <= '0;
            r_lead1 <= '0;
            r_lead2 <= '0;
            r_last  <= '0;
        end else if (r_busy) begin
            r_bcd  <= {4'd0, r_bcd[BCD_W-1:4]};
            r_sum  <= n_sum;
            r_last <= w_digit;
            if (w_digit != 4'd0) begin
                r_count <= COUNT_W'(r_idx) + COUNT_W'(1);
                r_lead1 <= w_digit;
                r_lead2 <= r_last;
            end
        end
    end

    always_comb begin
        o_res.luhn_ok     = (r_sum == 4'd0);
        o_res.digit_count = r_count;
        o_res.brand       = BRAND_INVALID;
        if (r_sum == 4'd0) begin
            if (r_count == COUNT_W'(15)) begin
                if (r_lead1 == 4'd3 && (r_lead2 == 4'd4 || r_lead2 == 4'd7)) begin
                    o_res.brand = BRAND_AMEX;
                end
            end else if (r_count == COUNT_W'(16)) begin
                if (r_lead1 == 4'd5 && r_lead2 >= 4'd1 && r_lead2 <= 4'd5) begin
                    o_res.brand = BRAND_MASTER;
                end else if (r_lead1 == 4'd4) begin
                    o_res.brand = BRAND_VISA;
                end
            end else if (r_count == COUNT_W'(13)) begin
                if (r_lead1 == 4'd4) begin
                    o_res.brand = BRAND_VISA;
                end
            end
        end
        // drop everything for a number longer than allowed
        if (r_count > COUNT_W'(MAX_DIGITS)) begin
            o_res = '0;
        end
    end

    assign o_done = r_done;

endmodule
